@@ rtl/csfm_pkg.sv @@
package csfm_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_TIPS    = 64;
  localparam int KEY_W       = 64;
  localparam int TIP_W       = 7;
  localparam int BIT_W       = $clog2(KEY_W);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 9;
  localparam int PROBE_LIMIT = 256;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_PROBE  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // one request as it travels down the row of cells
  typedef struct packed {
    logic [1:0]       req;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] limit;    // entries visible to this probe
    logic [IDX_W-1:0] slot;     // target cell of an insert
    logic             wr;       // insert actually stored
    logic             counted;  // probe counted towards the first hit
    logic             hit;
    logic [CNT_W-1:0] tidx;
    logic [CNT_W-1:0] item;
    logic [1:0]       status;
  } item_t;

  function automatic logic [KEY_W-1:0] low_mask(input logic [TIP_W-1:0] n);
    logic [KEY_W-1:0] m;
    if (n >= TIP_W'(KEY_W)) begin
      m = '1;
    end else begin
      m = (KEY_W'(1) << n) - KEY_W'(1);
    end
    return m;
  endfunction

  function automatic logic [TIP_W-1:0] eff_tips(input logic [TIP_W-1:0] tc);
    logic [TIP_W-1:0] n;
    n = tc;
    if (n < TIP_W'(2)) n = TIP_W'(2);
    if (n > TIP_W'(MAX_TIPS)) n = TIP_W'(MAX_TIPS);
    return n;
  endfunction

  function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] w,
                                                 input logic [TIP_W-1:0] n);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] mk;
    logic [KEY_W-1:0] v;
    logic [TIP_W-1:0] nm1;
    logic             top;
    m   = low_mask(n);
    nm1 = n - TIP_W'(1);
    mk  = low_mask(nm1);
    v   = w & m;
    top = v[nm1[BIT_W-1:0]];
    if (n[2:0] == 3'd0) begin
      if (!v[0]) v = ~v & m;
    end else if (n[2:0] == 3'd1) begin
      // last tip dropped from the key
      v = v & mk;
      if (!top) v = ~v & mk;
    end else begin
      if (v[0]) v = ~v & m;
    end
    return v;
  endfunction

endpackage

@@ rtl/csfm_cell.sv @@
module csfm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [csfm_pkg::IDX_W-1:0] cell_idx,
  input  logic                      in_valid,
  input  csfm_pkg::item_t           in_item,
  output logic                      out_valid,
  output csfm_pkg::item_t           out_item
);

  logic [csfm_pkg::KEY_W-1:0] key;
  csfm_pkg::item_t            item_next;

  always_comb begin
    item_next = in_item;
    if (in_item.req == csfm_pkg::REQ_PROBE && !in_item.hit &&
        csfm_pkg::CNT_W'(cell_idx) < in_item.limit && key == in_item.key) begin
      item_next.hit  = 1'b1;
      item_next.tidx = csfm_pkg::CNT_W'(cell_idx) + csfm_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
      // inserts ride behind earlier probes, so those never see the new key
      if (in_valid && in_item.wr && in_item.slot == cell_idx) begin
        key <= in_item.key;
      end
    end
  end

endmodule

@@ rtl/canonical_split_first_match.sv @@
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+-----------------------
//  in      | in_valid in_ready req_type split_bits     | in_valid & in_ready
//  out     | out_valid out_ready item_number hit ...   | out_valid & out_ready
//  cfg     | cfg_wr_en cfg_wr_data (tip_count)         | cfg_wr_en
//
//  one item per cycle while results are taken; stages: a front register,
//  one cell per table entry (256), then the output register
//  the whole row of cells moves together and holds while a result waits
//  reset clears counters, first-hit record and valid flags; keys are not cleared
module canonical_split_first_match (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                req_type,
  input  logic [63:0]               split_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [8:0]                item_number,
  output logic                      hit,
  output logic [8:0]                table_index,
  output logic [8:0]                first_probe,
  output logic [8:0]                first_table,
  output logic [1:0]                status,
  input  logic                      cfg_wr_en,
  input  logic [6:0]                cfg_wr_data
);

  localparam int N = csfm_pkg::MAX_ENTRIES;
  localparam int CW = csfm_pkg::CNT_W;

  logic [csfm_pkg::TIP_W-1:0] tip_count;
  logic [CW-1:0]              entry_count;
  logic [CW-1:0]              probe_count;
  logic [CW-1:0]              found_probe;
  logic [CW-1:0]              found_entry;
  logic [CW-1:0]              found_probe_next;
  logic [CW-1:0]              found_entry_next;
  logic                       advance;
  logic                       accept;
  csfm_pkg::item_t            front_next;
  csfm_pkg::item_t            chain_item  [N+1];
  logic                       chain_valid [N+1];
  csfm_pkg::item_t            tail;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tip_count <= csfm_pkg::TIP_W'(csfm_pkg::MAX_TIPS);
    end else if (cfg_wr_en) begin
      tip_count <= cfg_wr_data;
    end
  end

  // front: canonical key, entry and probe numbering
  always_comb begin
    front_next         = '0;
    front_next.req     = req_type;
    front_next.key     = csfm_pkg::canon_key(split_bits, csfm_pkg::eff_tips(tip_count));
    front_next.limit   = entry_count;
    front_next.slot    = entry_count[csfm_pkg::IDX_W-1:0];
    unique case (req_type)
      csfm_pkg::REQ_INSERT: begin
        if (entry_count < CW'(N)) begin
          front_next.wr   = 1'b1;
          front_next.item = entry_count + CW'(1);
        end else begin
          front_next.status = csfm_pkg::ST_FULL;
        end
      end
      csfm_pkg::REQ_PROBE: begin
        if (probe_count < CW'(csfm_pkg::PROBE_LIMIT)) begin
          front_next.counted = 1'b1;
          front_next.item    = probe_count + CW'(1);
        end else begin
          front_next.item   = CW'(csfm_pkg::PROBE_LIMIT);
          front_next.status = csfm_pkg::ST_SAT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      probe_count    <= '0;
      chain_valid[0] <= 1'b0;
    end else if (advance) begin
      chain_valid[0] <= in_valid;
      if (in_valid) begin
        if (req_type == csfm_pkg::REQ_CLEAR) begin
          entry_count <= '0;
          probe_count <= '0;
        end else begin
          if (front_next.wr) entry_count <= entry_count + CW'(1);
          if (front_next.counted) probe_count <= probe_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chain_item[0] <= front_next;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    csfm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .cell_idx  (csfm_pkg::IDX_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  assign tail = chain_item[N];

  // first-hit record follows the order in which results leave the row
  always_comb begin
    found_probe_next = found_probe;
    found_entry_next = found_entry;
    if (tail.req == csfm_pkg::REQ_CLEAR) begin
      found_probe_next = '0;
      found_entry_next = '0;
    end else if (tail.req == csfm_pkg::REQ_PROBE && tail.counted && tail.hit &&
                 found_probe == '0) begin
      found_probe_next = tail.item;
      found_entry_next = tail.tidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      found_probe <= '0;
      found_entry <= '0;
    end else if (advance) begin
      out_valid <= chain_valid[N];
      if (chain_valid[N]) begin
        found_probe <= found_probe_next;
        found_entry <= found_entry_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && chain_valid[N]) begin
      item_number <= tail.item;
      hit         <= tail.hit;
      table_index <= tail.tidx;
      status      <= tail.status;
      first_probe <= found_probe_next;
      first_table <= found_entry_next;
    end
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct packed {
    logic [8:0] item_number;
    logic       hit;
    logic [8:0] table_index;
    logic [8:0] first_probe;
    logic [8:0] first_table;
    logic [1:0] status;
  } split_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = csfm_pkg::REQ_CLEAR;
  logic [63:0] split_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [8:0]  item_number;
  logic        hit;
  logic [8:0]  table_index;
  logic [8:0]  first_probe;
  logic [8:0]  first_table;
  logic [1:0]  status;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  canonical_split_first_match uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .split_bits  (split_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_number (item_number),
    .hit         (hit),
    .table_index (table_index),
    .first_probe (first_probe),
    .first_table (first_table),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the block's table, counters and tip count register
  logic [63:0]   stored_keys [csfm_pkg::MAX_ENTRIES];
  int unsigned   key_total;
  int unsigned   probe_total;
  int unsigned   first_hit_probe;
  int unsigned   first_hit_entry;
  logic [6:0]    tip_setting = 7'd64;

  split_result_t pending_results [$];
  split_result_t want_result;
  split_result_t got_result;

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold = 0;
  int          rx_pause = 0;
  int          quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned hit_count = 0;
  int unsigned drop_count = 0;
  int unsigned saturated_count = 0;
  int unsigned settings_count = 0;

  function automatic int unsigned effective_tips();
    int unsigned n;
    n = 32'(tip_setting);
    if (n < 2) n = 2;
    if (n > csfm_pkg::MAX_TIPS) n = csfm_pkg::MAX_TIPS;
    return n;
  endfunction

  function automatic logic [63:0] used_bits_mask(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] canonical_key_of(input logic [63:0] w,
                                                  input int unsigned n);
    logic [63:0] full_mask;
    logic [63:0] kept_mask;
    logic [63:0] v;
    logic        top_tip;
    full_mask = used_bits_mask(n);
    v = w & full_mask;
    case (n % 8)
      0: begin
        if (!v[0]) v = ~v & full_mask;
      end
      1: begin
        // last tip leaves the key and decides the polarity
        kept_mask = used_bits_mask(n - 1);
        top_tip = v[n-1];
        v = v & kept_mask;
        if (!top_tip) v = ~v & kept_mask;
      end
      default: begin
        if (v[0]) v = ~v & full_mask;
      end
    endcase
    return v;
  endfunction

  function automatic split_result_t split_lookup_result(input logic [1:0] rt,
                                                        input logic [63:0] bits);
    split_result_t r;
    logic [63:0]   key;
    bit            found;
    int unsigned   idx;
    r = '0;
    found = 1'b0;
    idx = 0;
    key = canonical_key_of(bits, effective_tips());
    case (rt)
      csfm_pkg::REQ_CLEAR: begin
        key_total = 0;
        probe_total = 0;
        first_hit_probe = 0;
        first_hit_entry = 0;
      end
      csfm_pkg::REQ_INSERT: begin
        if (key_total < csfm_pkg::MAX_ENTRIES) begin
          stored_keys[key_total] = key;
          key_total++;
          r.item_number = 9'(key_total);
        end else begin
          r.status = csfm_pkg::ST_FULL;
          drop_count++;
        end
      end
      csfm_pkg::REQ_PROBE: begin
        // earliest entry wins on duplicates
        for (int i = 0; i < key_total && !found; i++) begin
          if (stored_keys[i] == key) begin
            found = 1'b1;
            idx = i + 1;
          end
        end
        r.hit = found;
        r.table_index = 9'(idx);
        if (found) hit_count++;
        if (probe_total < csfm_pkg::PROBE_LIMIT) begin
          probe_total++;
          r.item_number = 9'(probe_total);
          if (found && first_hit_probe == 0) begin
            first_hit_probe = probe_total;
            first_hit_entry = idx;
          end
        end else begin
          r.item_number = 9'(csfm_pkg::PROBE_LIMIT);
          r.status = csfm_pkg::ST_SAT;
          saturated_count++;
        end
      end
      default: begin
      end
    endcase
    r.first_probe = 9'(first_hit_probe);
    r.first_table = 9'(first_hit_entry);
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // same split written another way: complemented and/or junk above the tips
  function automatic logic [63:0] probe_variant(input logic [63:0] w,
                                                input int unsigned n);
    logic [63:0] junk;
    junk = random_word() & ~used_bits_mask(n);
    case ($urandom_range(0, 3))
      0: return w;
      1: return ~w;
      2: return w ^ junk;
      default: return ~w ^ junk;
    endcase
  endfunction

  function automatic logic [6:0] pick_tip_setting();
    case ($urandom_range(0, 13))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd3;
      4: return 7'd7;
      5: return 7'd8;
      6: return 7'd9;
      7: return 7'd17;
      8: return 7'd33;
      9: return 7'd57;
      10: return 7'd63;
      11: return 7'd65;
      12: return 7'd127;
      default: return 7'd64;
    endcase
  endfunction

  task automatic send_split(input logic [1:0] rt, input logic [63:0] bits);
    int unsigned gap;
    in_valid <= 1'b1;
    req_type <= rt;
    split_bits <= bits;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(split_lookup_result(rt, bits));
    sent_count++;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_tips(input logic [6:0] value);
    wait_until_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tip_setting = value;
    settings_count++;
  endtask

  task automatic run_mixed_traffic(input int count);
    logic [63:0] seen [$];
    logic [63:0] w;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_split(csfm_pkg::REQ_CLEAR, random_word());
        seen.delete();
      end else if (pick < 8) begin
        send_split(REQ_UNUSED, random_word());
      end else if (pick < 45 || seen.size() == 0) begin
        w = random_word();
        seen.push_back(w);
        send_split(csfm_pkg::REQ_INSERT, w);
      end else if (pick < 60) begin
        send_split(csfm_pkg::REQ_PROBE, random_word());
      end else begin
        w = seen[$urandom_range(0, seen.size() - 1)];
        send_split(csfm_pkg::REQ_PROBE, probe_variant(w, effective_tips()));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_split(csfm_pkg::REQ_CLEAR, '0);
    send_split(csfm_pkg::REQ_INSERT, 64'h0);
    send_split(csfm_pkg::REQ_INSERT, '1);
    send_split(csfm_pkg::REQ_PROBE, 64'h0);
    send_split(csfm_pkg::REQ_PROBE, 64'h5555_5555_5555_5555);
    send_split(csfm_pkg::REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_split(csfm_pkg::REQ_PROBE, 64'h5555_5555_5555_5555);
    send_split(REQ_UNUSED, '1);
    send_split(REQ_UNUSED, 64'h0);
    // one spare bit: the last tip drops out of the key
    set_tips(7'd9);
    send_split(csfm_pkg::REQ_CLEAR, '1);
    send_split(csfm_pkg::REQ_INSERT, '1);
    send_split(csfm_pkg::REQ_PROBE, 64'h0FF);
    send_split(csfm_pkg::REQ_PROBE, 64'h0);
    // below the minimum, runs as two tips
    set_tips(7'd0);
    send_split(csfm_pkg::REQ_CLEAR, '0);
    send_split(csfm_pkg::REQ_INSERT, 64'h2);
    send_split(csfm_pkg::REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFD);
    // above the maximum; the key stored at two tips keeps its form
    set_tips(7'd127);
    send_split(csfm_pkg::REQ_PROBE, 64'h0);
    send_split(csfm_pkg::REQ_INSERT, 64'h8000_0000_0000_0000);
    send_split(csfm_pkg::REQ_PROBE, 64'h7FFF_FFFF_FFFF_FFFF);
    set_tips(7'd13);
    send_split(csfm_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_E001);
    send_split(csfm_pkg::REQ_PROBE, 64'h0000_0000_0000_1FFE);
  endtask

  task automatic test_table_full();
    logic [63:0] seen [$];
    logic [63:0] w;
    set_tips(7'd40);
    send_split(csfm_pkg::REQ_CLEAR, random_word());
    for (int i = 0; i < csfm_pkg::MAX_ENTRIES + 6; i++) begin
      // the odd duplicate so the earliest entry has to win
      if (seen.size() != 0 && $urandom_range(0, 19) == 0) begin
        w = seen[$urandom_range(0, seen.size() - 1)];
      end else begin
        w = random_word();
      end
      seen.push_back(w);
      send_split(csfm_pkg::REQ_INSERT, w);
    end
    send_split(csfm_pkg::REQ_PROBE, seen[csfm_pkg::MAX_ENTRIES-1]);
    send_split(csfm_pkg::REQ_PROBE, seen[csfm_pkg::MAX_ENTRIES]);
    for (int i = 0; i < 10; i++) begin
      w = seen[$urandom_range(0, seen.size() - 1)];
      send_split(csfm_pkg::REQ_PROBE, probe_variant(w, effective_tips()));
    end
  endtask

  task automatic test_probe_saturation();
    logic [63:0] seen [$];
    logic [63:0] w;
    set_tips(pick_tip_setting());
    send_split(csfm_pkg::REQ_CLEAR, random_word());
    for (int i = 0; i < 20; i++) begin
      w = random_word();
      seen.push_back(w);
      send_split(csfm_pkg::REQ_INSERT, w);
    end
    // misses first so the first hit lands late
    for (int i = 0; i < csfm_pkg::PROBE_LIMIT + 14; i++) begin
      if (i < 40 || $urandom_range(0, 1) == 0) begin
        send_split(csfm_pkg::REQ_PROBE, random_word());
      end else begin
        w = seen[$urandom_range(0, seen.size() - 1)];
        send_split(csfm_pkg::REQ_PROBE, probe_variant(w, effective_tips()));
      end
    end
  endtask

  task automatic test_backpressure();
    set_tips(pick_tip_setting());
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_split(csfm_pkg::REQ_CLEAR, random_word());
    // long stall on the result side so the pipe fills and stops taking input
    rx_hold = 700;
    run_mixed_traffic(400);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 10; phase++) begin
      set_tips(pick_tip_setting());
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      // without a clear, keys from the old tip count stay in the table
      if ($urandom_range(0, 1) == 0) send_split(csfm_pkg::REQ_CLEAR, random_word());
      run_mixed_traffic(55);
    end
  endtask

  // result side: stalls, then checks each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_result = {item_number, hit, table_index, first_probe, first_table, status};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result %p", $time, got_result);
        end else begin
          want_result = pending_results.pop_front();
          checked_count++;
          if (got_result.item_number !== want_result.item_number ||
              got_result.hit !== want_result.hit ||
              got_result.table_index !== want_result.table_index ||
              got_result.first_probe !== want_result.first_probe ||
              got_result.first_table !== want_result.first_table ||
              got_result.status !== want_result.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result %0d expected %p", $time, checked_count, want_result);
              $display("%0t: result %0d actual   %p", $time, checked_count, got_result);
            end
          end
        end
        rx_pause = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_pause > 0) begin
        rx_pause--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_table_full();
    test_probe_saturation();
    test_backpressure();
    test_random_settings();
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests checked over %0d tip count writes", checked_count, settings_count);
    $display("%0d probe hits, %0d inserts dropped on a full table, %0d saturated probes",
             hit_count, drop_count, saturated_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
